>>> hdl/msb_pkg.sv
// Package for the merge sort buffer: sizing constants and the controller to
// datapath command and status types. No dependencies.
package msb_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   // Wide enough for lo + 2*width during a pass and for the element count.
   localparam int IDX_W    = $clog2(2 * CAPACITY);

   typedef struct packed {
      logic              load;      // write data comes from the request
      logic              wr_en;
      logic              wr_sel;    // 0: bank 0, 1: bank 1
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_sel;    // bank that holds the source run
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              take_a;    // merge picks the left head
      logic              cap_out;   // capture left head into response register
   } cmd_type;

   typedef struct packed {
      logic a_le_b;
   } sts_type;

endpackage

>>> hdl/msb_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module msb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hdl/msb_ctrl.sv
// Sequencer for the merge sort buffer: load, bottom-up merge passes and
// response output. Depends on msb_pkg.
module msb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_final_item,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_end_of_run,
   output logic             rsp_overflow,
   output msb_pkg::cmd_type cmd,
   input  msb_pkg::sts_type sts
);
   import msb_pkg::*;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_SEG   = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_WR    = 3'd3;
   localparam logic [2:0] S_ORD   = 3'd4;
   localparam logic [2:0] S_OCAP  = 3'd5;
   localparam logic [2:0] S_OWAIT = 3'd6;

   localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);
   localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] w_ff, w_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             has_room;
   logic [IDX_W-1:0] n_new;
   logic [IDX_W-1:0] lo_w;
   logic [IDX_W-1:0] w2;
   logic [IDX_W-1:0] lo_2w;
   logic [IDX_W-1:0] k_inc;
   logic             take_a;

   assign has_room = (count_ff < CAP_IDX);
   assign n_new    = has_room ? count_ff + ONE : count_ff;
   assign lo_w     = lo_ff + w_ff;
   assign w2       = {w_ff[IDX_W-2:0], 1'b0};
   assign lo_2w    = lo_ff + w2;
   assign k_inc    = k_ff + ONE;
   assign take_a   = (i_ff < mid_ff) && ((j_ff >= hi_ff) || sts.a_le_b);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      w_in         = w_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;

      cmd           = '0;
      cmd.rd_sel    = sel_ff;
      cmd.rd_addr_a = i_ff[ADDR_W-1:0];
      cmd.rd_addr_b = j_ff[ADDR_W-1:0];
      cmd.take_a    = take_a;

      unique case (state_ff)
         S_LOAD: begin
            cmd.load    = 1'b1;
            cmd.wr_sel  = 1'b0;
            cmd.wr_addr = count_ff[ADDR_W-1:0];
            if (req_valid) begin
               cmd.wr_en = has_room;
               count_in  = n_new;
               if (!has_room) begin
                  dropped_in = 1'b1;
               end
               if (req_final_item) begin
                  sel_in = 1'b0;
                  lo_in  = '0;
                  w_in   = ONE;
                  k_in   = '0;
                  state_in = (n_new == ONE) ? S_ORD : S_SEG;
               end
            end
         end
         S_SEG: begin
            mid_in   = (lo_w > count_ff) ? count_ff : lo_w;
            hi_in    = (lo_2w > count_ff) ? count_ff : lo_2w;
            i_in     = lo_ff;
            j_in     = (lo_w > count_ff) ? count_ff : lo_w;
            k_in     = lo_ff;
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = !sel_ff;
            cmd.wr_addr = k_ff[ADDR_W-1:0];
            if (take_a) begin
               i_in = i_ff + ONE;
            end else begin
               j_in = j_ff + ONE;
            end
            k_in = k_inc;
            if (k_inc == hi_ff) begin
               if (lo_2w >= count_ff) begin
                  w_in   = w2;
                  sel_in = !sel_ff;
                  lo_in  = '0;
                  if (w2 >= count_ff) begin
                     k_in     = '0;
                     state_in = S_ORD;
                  end else begin
                     state_in = S_SEG;
                  end
               end else begin
                  lo_in    = lo_2w;
                  state_in = S_SEG;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_ORD: begin
            cmd.rd_addr_a = k_ff[ADDR_W-1:0];
            state_in      = S_OCAP;
         end
         S_OCAP: begin
            cmd.cap_out  = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_last_in  = (k_inc == count_ff);
            state_in     = S_OWAIT;
         end
         S_OWAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  k_in     = k_inc;
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
   end

   assign req_stall      = (state_ff != S_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_end_of_run = rsp_last_ff;
   assign rsp_overflow   = dropped_ff;

`ifndef SYNTHESIS
   a_valid_only_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OWAIT))
      else $error("response valid outside the output wait state");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_IDX)
      else $error("element count beyond capacity");

   a_merge_in_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (k_ff < hi_ff && i_ff <= mid_ff && j_ff <= hi_ff
                              && (i_ff < mid_ff || j_ff < hi_ff)))
      else $error("merge indices outside the segment");

   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (k_inc == count_ff))
      else $error("end of run flagged on the wrong element");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_last_ff) |=>
         (count_ff == '0 && !dropped_ff && state_ff == S_LOAD))
      else $error("set not cleared after the final response");
`endif

endmodule

>>> hdl/msb_dp.sv
// Datapath for the merge sort buffer: two ping-pong RAM banks, the signed
// compare of the two run heads and the response data register.
// Depends on msb_pkg and msb_ram.
module msb_dp (
   input  logic                               clock,
   input  logic signed [msb_pkg::DATA_W-1:0]  req_value,
   output logic signed [msb_pkg::DATA_W-1:0]  rsp_sorted_value,
   input  msb_pkg::cmd_type                   cmd,
   output msb_pkg::sts_type                   sts
);
   import msb_pkg::*;

   logic [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b;
   logic [DATA_W-1:0] src_a, src_b;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] out_ff;

   msb_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_bank0 (
      .clock     (clock),
      .wr_en     (cmd.wr_en && !cmd.wr_sel),
      .wr_addr   (cmd.wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (cmd.rd_addr_a),
      .rd_addr_b (cmd.rd_addr_b),
      .rd_data_a (b0_a),
      .rd_data_b (b0_b)
   );

   msb_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_bank1 (
      .clock     (clock),
      .wr_en     (cmd.wr_en && cmd.wr_sel),
      .wr_addr   (cmd.wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (cmd.rd_addr_a),
      .rd_addr_b (cmd.rd_addr_b),
      .rd_data_a (b1_a),
      .rd_data_b (b1_b)
   );

   assign src_a = cmd.rd_sel ? b1_a : b0_a;
   assign src_b = cmd.rd_sel ? b1_b : b0_b;

   // Left head wins ties to keep the sort stable.
   assign sts.a_le_b = ($signed(src_a) <= $signed(src_b));

   assign wr_data = cmd.load ? req_value : (cmd.take_a ? src_a : src_b);

   always_ff @(posedge clock) begin
      if (cmd.cap_out) begin
         out_ff <= src_a;
      end
   end

   assign rsp_sorted_value = out_ff;

endmodule

>>> hdl/merge_sort_buffer.sv
// Merge sort buffer top level; depends on msb_pkg, msb_ctrl, msb_dp and msb_ram.
// Load: one request per cycle, stall low in load. Sort of n elements: ceil(log2 n)
// merge passes; each element of a pass is a registered RAM read then a write, plus
// a setup step per merged segment. The first response is read, then captured.
// Output: each response is read, captured and held until taken, then the next is read.
// Reset: synchronous, active high; clears sequencer, count and overflow flag only.
module merge_sort_buffer (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [msb_pkg::DATA_W-1:0] req_value,
   input  logic                              req_final_item,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [msb_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_run,
   output logic                              rsp_overflow
);
   import msb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: takes requests into bank 0, walks the bottom-up merge passes
   // between the two banks, then streams the sorted run out.
   msb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_item (req_final_item),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_overflow   (rsp_overflow),
      .cmd            (cmd),
      .sts            (sts)
   );

   // Datapath: storage banks, head compare and the response data register.
   // RAM banks are not cleared, as only entries of the current set are read.
   msb_dp u_dp (
      .clock            (clock),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
